/* sv/hwbf_pkg.sv */
// ----------------------------------------------------------------------------
// hwbf_pkg
// Shared types and constants for the Haar wavelet block fusion core.
// ----------------------------------------------------------------------------
package hwbf_pkg;

  // Pixel width of both source images and of the fused image
  localparam int unsigned PIX_W   = 8;
  // Width of the low-low coefficient (sum of four pixels, kept signed)
  localparam int unsigned LL_W    = PIX_W + 3;
  // Width of a detail coefficient (signed, +-2 * 255)
  localparam int unsigned DET_W   = PIX_W + 2;
  // Width of a fused detail term after the doubling of the inverse transform
  localparam int unsigned FDET_W  = DET_W + 1;
  // Width of the fused pixel numerator before the divide by eight
  localparam int unsigned SUM_W   = PIX_W + 6;
  // Scale applied to each fused detail coefficient
  localparam int unsigned HALF_DIV = 2;
  // Bits dropped by the final divide by eight
  localparam int unsigned FRAC_W  = 3;
  // Default number of transform lanes (one per source image)
  localparam int unsigned NUM_LANES = 2;

  // One 2x2 block from one image
  typedef struct packed {
    logic [PIX_W-1:0] top_left;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] bottom_left;
    logic [PIX_W-1:0] bottom_right;
  } blk_t;

  // Input request: the same block from both images
  typedef struct packed {
    logic [PIX_W-1:0] a_top_left;
    logic [PIX_W-1:0] a_top_right;
    logic [PIX_W-1:0] a_bottom_left;
    logic [PIX_W-1:0] a_bottom_right;
    logic [PIX_W-1:0] b_top_left;
    logic [PIX_W-1:0] b_top_right;
    logic [PIX_W-1:0] b_bottom_left;
    logic [PIX_W-1:0] b_bottom_right;
  } in_t;

  // Result request: the fused block
  typedef struct packed {
    logic [PIX_W-1:0] fused_top_left;
    logic [PIX_W-1:0] fused_top_right;
    logic [PIX_W-1:0] fused_bottom_left;
    logic [PIX_W-1:0] fused_bottom_right;
  } out_t;

  // Forward Haar coefficients of one block
  typedef struct packed {
    logic signed [LL_W-1:0]  ll;
    logic signed [DET_W-1:0] hl;
    logic signed [DET_W-1:0] lh;
    logic signed [DET_W-1:0] hh;
  } coef_t;

endpackage

/* sv/haar_wavelet_block_fusion_core.sv */
// Haar wavelet block fusion core. Each request carries the same 2x2 block
// from two grayscale images; the result is the fused 2x2 block. One request
// is taken every cycle unless output back-pressure stalls the input, and its result passes in order:
// the first register stage holds the forward Haar coefficients from the per-image
// lanes, the second holds the fused, rounded and saturated pixels. The core
// has no state between requests and needs no setup after reset.
// ----------------------------------------------------------------------------
// haar_wavelet_block_fusion_core
// Top level: transform lanes, coefficient register, merge and output register.
// ----------------------------------------------------------------------------
module haar_wavelet_block_fusion_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hwbf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output hwbf_pkg::out_t  out_data
);

  // One lane per source image
  localparam int unsigned NUM_LANES = hwbf_pkg::NUM_LANES;

  hwbf_pkg::blk_t  lane_blk [NUM_LANES];
  hwbf_pkg::coef_t lane_coef[NUM_LANES];
  hwbf_pkg::coef_t coef_r   [NUM_LANES];
  hwbf_pkg::coef_t coef_nxt [NUM_LANES];
  hwbf_pkg::out_t  fused;
  hwbf_pkg::out_t  out_data_r;
  logic            coef_vld_r, coef_vld_nxt;
  logic            out_vld_r,  out_vld_nxt;
  logic            out_adv;
  logic            coef_adv;

  // Split the request into one block per image
  always_comb begin
    lane_blk[0] = '{in_data.a_top_left, in_data.a_top_right,
                    in_data.a_bottom_left, in_data.a_bottom_right};
    lane_blk[NUM_LANES-1] = '{in_data.b_top_left, in_data.b_top_right,
                              in_data.b_bottom_left, in_data.b_bottom_right};
  end

  // Forward transform lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    hwbf_lane u_lane (
      .blk  (lane_blk[g]),
      .coef (lane_coef[g])
    );
  end

  // Advance the output stage when it is empty or being drained
  assign out_adv  = !out_vld_r || !out_stall;
  assign coef_adv = !coef_vld_r || out_adv;
  assign in_stall = !coef_adv;

  // Next state of both stages
  always_comb begin
    coef_vld_nxt = coef_adv ? in_valid : coef_vld_r;
    out_vld_nxt  = out_adv  ? coef_vld_r : out_vld_r;
    for (int i = 0; i < NUM_LANES; i++) begin
      coef_nxt[i] = (coef_adv && in_valid) ? lane_coef[i] : coef_r[i];
    end
  end

  // Merge the lanes: fuse coefficients and invert
  hwbf_merge u_merge (
    .coef_a (coef_r[0]),
    .coef_b (coef_r[NUM_LANES-1]),
    .fused  (fused)
  );

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      coef_vld_r <= coef_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    if (out_adv && coef_vld_r) begin
      out_data_r <= fused;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

/* sv/hwbf_lane.sv */
// ----------------------------------------------------------------------------
// hwbf_lane
// Forward unnormalised 2-D Haar transform of one 2x2 pixel block.
// ----------------------------------------------------------------------------
module hwbf_lane (
  input  hwbf_pkg::blk_t  blk,
  output hwbf_pkg::coef_t coef
);

  logic signed [hwbf_pkg::LL_W-1:0] tl, tr, bl, br;
  logic signed [hwbf_pkg::LL_W-1:0] s0, s1, d0, d1;
  logic signed [hwbf_pkg::LL_W-1:0] hl_w, lh_w, hh_w;

  // Widen the pixels to signed and form row sums and differences
  always_comb begin
    tl = $signed({{(hwbf_pkg::LL_W-hwbf_pkg::PIX_W){1'b0}}, blk.top_left});
    tr = $signed({{(hwbf_pkg::LL_W-hwbf_pkg::PIX_W){1'b0}}, blk.top_right});
    bl = $signed({{(hwbf_pkg::LL_W-hwbf_pkg::PIX_W){1'b0}}, blk.bottom_left});
    br = $signed({{(hwbf_pkg::LL_W-hwbf_pkg::PIX_W){1'b0}}, blk.bottom_right});
    s0 = tl + tr;
    d0 = tl - tr;
    s1 = bl + br;
    d1 = bl - br;
    hl_w = d0 + d1;
    lh_w = s0 - s1;
    hh_w = d0 - d1;
  end

  // Combine rows into the four coefficients; details fit DET_W bits
  always_comb begin
    coef.ll = s0 + s1;
    coef.hl = hl_w[hwbf_pkg::DET_W-1:0];
    coef.lh = lh_w[hwbf_pkg::DET_W-1:0];
    coef.hh = hh_w[hwbf_pkg::DET_W-1:0];
  end

endmodule

/* sv/hwbf_merge.sv */
// ----------------------------------------------------------------------------
// hwbf_merge
// Fuse the coefficients of two lanes and run the inverse transform, with
// round-half-to-even and saturation of each fused pixel.
// ----------------------------------------------------------------------------
module hwbf_merge (
  input  hwbf_pkg::coef_t coef_a,
  input  hwbf_pkg::coef_t coef_b,
  output hwbf_pkg::out_t  fused
);

  localparam int unsigned Q_W = hwbf_pkg::SUM_W - hwbf_pkg::FRAC_W;

  logic signed [hwbf_pkg::SUM_W-1:0]   s_sum;
  logic signed [hwbf_pkg::DET_W-1:0]   hl_max, lh_max, hh_max;
  logic signed [hwbf_pkg::SUM_W-1:0]   hl_f, lh_f, hh_f;
  logic signed [hwbf_pkg::SUM_W-1:0]   n_tl, n_tr, n_bl, n_br;

  // Divide by eight, round half to even, clamp to the pixel range
  function automatic logic [hwbf_pkg::PIX_W-1:0] round_sat(
    input logic signed [hwbf_pkg::SUM_W-1:0] n
  );
    logic [Q_W-1:0]                q;
    logic [hwbf_pkg::FRAC_W-1:0]   r;
    logic [Q_W:0]                  qr;
    logic                          up;
    q  = n[hwbf_pkg::SUM_W-1:hwbf_pkg::FRAC_W];
    r  = n[hwbf_pkg::FRAC_W-1:0];
    up = (r > 3'd4) || ((r == 3'd4) && q[0]);
    qr = {1'b0, q} + {{Q_W{1'b0}}, up};
    if (n[hwbf_pkg::SUM_W-1] || (n == '0)) begin
      round_sat = '0;
    end else if (qr > (Q_W+1)'((1 << hwbf_pkg::PIX_W) - 1)) begin
      round_sat = '1;
    end else begin
      round_sat = qr[hwbf_pkg::PIX_W-1:0];
    end
  endfunction

  // Average LL (kept as the sum) and take the signed maximum of each detail
  always_comb begin
    s_sum  = hwbf_pkg::SUM_W'(coef_a.ll) + hwbf_pkg::SUM_W'(coef_b.ll);
    hl_max = (coef_a.hl > coef_b.hl) ? coef_a.hl : coef_b.hl;
    lh_max = (coef_a.lh > coef_b.lh) ? coef_a.lh : coef_b.lh;
    hh_max = (coef_a.hh > coef_b.hh) ? coef_a.hh : coef_b.hh;
    hl_f   = hwbf_pkg::SUM_W'(hl_max) * $signed(hwbf_pkg::SUM_W'(hwbf_pkg::HALF_DIV));
    lh_f   = hwbf_pkg::SUM_W'(lh_max) * $signed(hwbf_pkg::SUM_W'(hwbf_pkg::HALF_DIV));
    hh_f   = hwbf_pkg::SUM_W'(hh_max) * $signed(hwbf_pkg::SUM_W'(hwbf_pkg::HALF_DIV));
  end

  // Inverse transform: one signed sum per pixel position
  always_comb begin
    n_tl = s_sum + lh_f + hl_f + hh_f;
    n_tr = s_sum + lh_f - hl_f - hh_f;
    n_bl = s_sum - lh_f + hl_f - hh_f;
    n_br = s_sum - lh_f - hl_f + hh_f;
    fused.fused_top_left     = round_sat(n_tl);
    fused.fused_top_right    = round_sat(n_tr);
    fused.fused_bottom_left  = round_sat(n_bl);
    fused.fused_bottom_right = round_sat(n_br);
  end

endmodule

/* sv/hwbf_checker.sv */
// ----------------------------------------------------------------------------
// hwbf_checker
// Port-level checks on the fusion core's request and result channels.
// ----------------------------------------------------------------------------
module hwbf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input hwbf_pkg::out_t out_data
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Back-pressure only when the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // An accepted request shows a valid result after the coefficient and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("result missing after accepted request");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind haar_wavelet_block_fusion_core hwbf_checker u_hwbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
